// ----- hdl/ttbm_pkg.sv -----
// Package for the text token boundary marker.
// Holds the output codes, tokenizer state encodings, character constants and
// the struct that the classifier hands to the top level. No dependencies.
package ttbm_pkg;

	localparam int MAX_BUFFER = 65536;
	localparam int POS_W      = 16;
	localparam int POS_MAX    = (1 << POS_W) - 1;
	// last index the byte counter may reach
	localparam int INDEX_LIMIT_INT = (MAX_BUFFER - 1 > POS_MAX) ? POS_MAX : (MAX_BUFFER - 1);
	localparam logic [POS_W-1:0] INDEX_LIMIT = INDEX_LIMIT_INT[POS_W-1:0];

	typedef enum logic [1:0] {
		ROLE_SKIP  = 2'd0,
		ROLE_BEGIN = 2'd1,
		ROLE_CONT  = 2'd2
	} role_t;

	typedef enum logic [2:0] {
		KIND_NONE   = 3'd0,
		KIND_NUMBER = 3'd1,
		KIND_IDENT  = 3'd2,
		KIND_SYMBOL = 3'd3,
		KIND_LINE   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		CLS_NONE   = 2'd0,
		CLS_NUMBER = 2'd1,
		CLS_IDENT  = 2'd2
	} open_class_t;

	typedef enum logic [1:0] {
		PHASE_START    = 2'd0,
		PHASE_INSIDE   = 2'd1,
		PHASE_AFTER_CR = 2'd2,
		PHASE_AFTER_LF = 2'd3
	} phase_t;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;

	typedef struct packed {
		role_t       role;
		kind_t       kind;
		open_class_t open_class;
		phase_t      line_phase;
	} cls_res_t;

endpackage

// ----- hdl/ttbm_classify.sv -----
// Byte classifier for the token boundary marker: labels one byte and gives
// the next tokenizer/line state. Purely combinational. Depends on ttbm_pkg.
module ttbm_classify (
	input  logic [7:0]             ch,
	input  logic                   line_mode,
	input  ttbm_pkg::open_class_t  open_class,
	input  ttbm_pkg::phase_t       line_phase,
	output ttbm_pkg::cls_res_t     res
);
	import ttbm_pkg::*;

	logic is_digit, is_letter, is_space, is_num_more, pair;
	phase_t phase_nl;

	assign is_digit    = (ch >= CH_0) && (ch <= CH_9);
	assign is_letter   = ((ch >= CH_LA) && (ch <= CH_LZ)) || ((ch >= CH_UA) && (ch <= CH_UZ)) ||
	                     (ch == CH_UNDER);
	assign is_space    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
	assign is_num_more = is_digit || (ch == CH_MINUS) || (ch == CH_PLUS) || (ch == CH_E) ||
	                     (ch == CH_DOT);
	// CR LF and LF CR collapse into one newline
	assign pair = ((line_phase == PHASE_AFTER_CR) && (ch == CH_LF)) ||
	              ((line_phase == PHASE_AFTER_LF) && (ch == CH_CR));

	always_comb begin
		priority if (ch == CH_CR) phase_nl = PHASE_AFTER_CR;
		else if (ch == CH_LF) phase_nl = PHASE_AFTER_LF;
		else phase_nl = PHASE_INSIDE;
	end

	always_comb begin
		res.open_class = open_class;
		res.line_phase = line_phase;
		if (line_mode) begin
			res.kind = KIND_LINE;
			priority if (pair) begin
				res.role       = ROLE_CONT;
				res.line_phase = PHASE_START;
			end else if (line_phase == PHASE_INSIDE) begin
				res.role       = ROLE_CONT;
				res.line_phase = phase_nl;
			end else begin
				res.role       = ROLE_BEGIN;
				res.line_phase = phase_nl;
			end
		end else begin
			priority if ((open_class == CLS_NUMBER) && is_num_more) begin
				res.role = ROLE_CONT;
				res.kind = KIND_NUMBER;
			end else if ((open_class == CLS_IDENT) && (is_letter || is_digit)) begin
				res.role = ROLE_CONT;
				res.kind = KIND_IDENT;
			end else if (is_space) begin
				res.role       = ROLE_SKIP;
				res.kind       = KIND_NONE;
				res.open_class = CLS_NONE;
			end else if (is_digit) begin
				res.role       = ROLE_BEGIN;
				res.kind       = KIND_NUMBER;
				res.open_class = CLS_NUMBER;
			end else if (is_letter) begin
				res.role       = ROLE_BEGIN;
				res.kind       = KIND_IDENT;
				res.open_class = CLS_IDENT;
			end else begin
				res.role       = ROLE_BEGIN;
				res.kind       = KIND_SYMBOL;
				res.open_class = CLS_NONE;
			end
		end
	end

endmodule

// ----- hdl/text_token_boundary_marker.sv -----
// Top level of the text token boundary marker: state registers, byte counter
// and the output register. Depends on ttbm_pkg and ttbm_classify.
// Results are registered: each accepted input transaction loads the output register.
// Throughput: one byte per cycle; the only back-pressure is a held output
// register, which stalls the input in the same cycle.
// Reset: token mode, no token open, line start, byte index zero, output empty.
module text_token_boundary_marker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ch,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  role,
	output logic [2:0]  kind,
	output logic [15:0] position,
	output logic        buffer_end
);
	import ttbm_pkg::*;

	logic             line_mode_q;
	open_class_t      open_class_q;
	phase_t           line_phase_q;
	logic [POS_W-1:0] byte_index_q;
	logic             out_valid_q;
	logic             accept;
	cls_res_t         cls;

	ttbm_classify u_classify (
		.ch         (ch),
		.line_mode  (line_mode_q),
		.open_class (open_class_q),
		.line_phase (line_phase_q),
		.res        (cls)
	);

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_mode_q  <= 1'b0;
			open_class_q <= CLS_NONE;
			line_phase_q <= PHASE_START;
			byte_index_q <= '0;
		end else if (cfg_wr_en) begin
			line_mode_q  <= cfg_wr_data;
			open_class_q <= CLS_NONE;
			line_phase_q <= PHASE_START;
		end else if (accept) begin
			if (final_byte) begin
				open_class_q <= CLS_NONE;
				line_phase_q <= PHASE_START;
				byte_index_q <= '0;
			end else begin
				open_class_q <= cls.open_class;
				line_phase_q <= cls.line_phase;
				if (byte_index_q < INDEX_LIMIT) byte_index_q <= byte_index_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			role       <= cls.role;
			kind       <= cls.kind;
			position   <= byte_index_q;
			buffer_end <= final_byte;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- dv/tb_top.sv -----
// Testbench for text_token_boundary_marker: directed and random byte streams in
// token and line mode, each labeled result checked against an in-bench tokenizer.
// Depends on ttbm_pkg and the text_token_boundary_marker RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ttbm_pkg::*;

	localparam int TIMEOUT_CYCLES = 1000000;
	localparam int HOLD_CYCLES    = 200;
	localparam int SETTLE_CYCLES  = 4;
	localparam int LONG_BYTES     = 64;
	localparam int RAND_BYTES     = 130;
	localparam int MAX_PRINTS     = 60;

	typedef struct {
		role_t       role;
		kind_t       kind;
		logic [15:0] position;
		logic        buffer_end;
	} byte_label_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [7:0]  ch          = 8'h00;
	logic        final_byte  = 1'b0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [1:0]  role;
	logic [2:0]  kind;
	logic [15:0] position;
	logic        buffer_end;

	// tokenizer state mirrored in the bench
	logic        tok_line_mode = 1'b0;
	open_class_t tok_open      = CLS_NONE;
	phase_t      tok_phase     = PHASE_START;
	logic [15:0] tok_index     = '0;

	byte_label_t pending_labels[$];
	int          errors    = 0;
	int          cycles    = 0;
	int          idle_pct  = 0;
	int          stall_pct = 0;
	logic        hold_on   = 1'b0;
	event        hold_go;

	text_token_boundary_marker DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.ch          (ch),
		.final_byte  (final_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.role        (role),
		.kind        (kind),
		.position    (position),
		.buffer_end  (buffer_end)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_labels.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic is_digit_ch(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic logic is_word_ch(input logic [7:0] c);
		return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_UNDER;
	endfunction

	function automatic logic is_blank_ch(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic phase_t phase_after_ch(input logic [7:0] c);
		if (c == CH_CR)
			return PHASE_AFTER_CR;
		if (c == CH_LF)
			return PHASE_AFTER_LF;
		return PHASE_INSIDE;
	endfunction

	// Labels one byte and advances the mirrored tokenizer state.
	function automatic byte_label_t label_byte(input logic [7:0] c, input logic fin);
		byte_label_t lb;
		logic        nl_pair;
		logic        num_tail;
		lb.position   = tok_index;
		lb.buffer_end = fin;
		if (tok_line_mode) begin
			nl_pair = (tok_phase == PHASE_AFTER_CR && c == CH_LF) ||
				(tok_phase == PHASE_AFTER_LF && c == CH_CR);
			lb.kind = KIND_LINE;
			if (nl_pair) begin
				lb.role   = ROLE_CONT;
				tok_phase = PHASE_START;
			end else if (tok_phase == PHASE_INSIDE) begin
				lb.role   = ROLE_CONT;
				tok_phase = phase_after_ch(c);
			end else begin
				lb.role   = ROLE_BEGIN;
				tok_phase = phase_after_ch(c);
			end
		end else begin
			num_tail = is_digit_ch(c) || c == CH_MINUS || c == CH_PLUS || c == CH_E ||
				c == CH_DOT;
			if (tok_open == CLS_NUMBER && num_tail) begin
				lb.role = ROLE_CONT;
				lb.kind = KIND_NUMBER;
			end else if (tok_open == CLS_IDENT && (is_word_ch(c) || is_digit_ch(c))) begin
				lb.role = ROLE_CONT;
				lb.kind = KIND_IDENT;
			end else if (is_blank_ch(c)) begin
				lb.role  = ROLE_SKIP;
				lb.kind  = KIND_NONE;
				tok_open = CLS_NONE;
			end else if (is_digit_ch(c)) begin
				lb.role  = ROLE_BEGIN;
				lb.kind  = KIND_NUMBER;
				tok_open = CLS_NUMBER;
			end else if (is_word_ch(c)) begin
				lb.role  = ROLE_BEGIN;
				lb.kind  = KIND_IDENT;
				tok_open = CLS_IDENT;
			end else begin
				lb.role  = ROLE_BEGIN;
				lb.kind  = KIND_SYMBOL;
				tok_open = CLS_NONE;
			end
		end
		if (fin) begin
			tok_open  = CLS_NONE;
			tok_phase = PHASE_START;
			tok_index = '0;
		end else if (tok_index < INDEX_LIMIT) begin
			tok_index = tok_index + 16'd1;
		end
		return lb;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("mismatch at cycle %0d: %s", cycles, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// receiver: random stalls, or a solid hold-off while hold_on is set
	always @(posedge clk) begin
		out_stall <= hold_on || (stall_pct != 0 && $urandom_range(99) < stall_pct);
	end

	initial begin
		forever begin
			@(hold_go);
			hold_on <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_out
		byte_label_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_labels.size() == 0) begin
				report_mismatch("result transaction with nothing expected");
			end else begin
				want = pending_labels.pop_front();
				check_field("role", 16'(role), 16'(want.role));
				check_field("kind", 16'(kind), 16'(want.kind));
				check_field("position", position, want.position);
				check_field("buffer_end", 16'(buffer_end), 16'(want.buffer_end));
			end
		end
	end

	// Offers one byte, waits for the transaction, then maybe idles.
	task automatic send_byte(input logic [7:0] c, input logic fin);
		int gap;
		in_valid   <= 1'b1;
		ch         <= c;
		final_byte <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_labels.push_back(label_byte(c, fin));
		gap = 0;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s, input logic fin_on_last);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], fin_on_last && i == s.len() - 1);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_labels.size() != 0) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic set_line_mode(input logic m);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en     <= 1'b0;
		tok_line_mode = m;
		tok_open      = CLS_NONE;
		tok_phase     = PHASE_START;
	endtask

	// mostly text-like bytes, some raw noise
	function automatic logic [7:0] text_byte();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return CH_0 + 8'($urandom_range(9));
		if (r < 50)
			return ($urandom_range(1) ? CH_LA : CH_UA) + 8'($urandom_range(25));
		if (r < 53)
			return CH_UNDER;
		if (r < 61)
			return $urandom_range(1) ? CH_SPACE : CH_TAB;
		if (r < 71)
			return $urandom_range(1) ? CH_CR : CH_LF;
		if (r < 81) begin
			case ($urandom_range(3))
				0: return CH_MINUS;
				1: return CH_PLUS;
				2: return CH_E;
				default: return CH_DOT;
			endcase
		end
		return 8'($urandom_range(255));
	endfunction

	task automatic test_token_classes;
		idle_pct  = 0;
		stall_pct = 0;
		set_line_mode(1'b0);
		send_text("12.5e-3+x7", 1'b0);
		send_text(" _ab9E.", 1'b0);
		send_text("\t\r\n", 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("#", 1'b1);
		drain();
	endtask

	task automatic test_line_pairs;
		set_line_mode(1'b1);
		send_text("ab\r\nc\n\rd\r\r\n\ne\r", 1'b1);
		// an LF right after the buffer end must not pair with the CR
		send_text("\nx", 1'b1);
		drain();
	endtask

	task automatic test_buffer_end;
		set_line_mode(1'b0);
		send_text("42", 1'b1);
		send_text("7 q", 1'b1);
		drain();
	endtask

	task automatic test_mode_change;
		send_text("ab", 1'b0);
		drain();
		set_line_mode(1'b0);
		send_text("c", 1'b0);
		drain();
		set_line_mode(1'b1);
		send_text("x\r", 1'b0);
		drain();
		set_line_mode(1'b1);
		send_text("\nq", 1'b1);
		drain();
	endtask

	// byte index counts up across a long buffer and restarts after its end
	task automatic test_index_count;
		idle_pct  = 0;
		stall_pct = 0;
		set_line_mode(1'b0);
		for (int i = 0; i < LONG_BYTES; i++)
			send_byte(8'($urandom_range(255)), 1'b0);
		send_byte(8'($urandom_range(255)), 1'b1);
		drain();
	endtask

	task automatic test_backpressure;
		idle_pct  = 0;
		stall_pct = 0;
		-> hold_go;
		repeat (40) send_byte(text_byte(), $urandom_range(15) == 0);
		drain();
	endtask

	task automatic test_random_text;
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 84; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 84; end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase
			set_line_mode(p >= 4);
			repeat (RAND_BYTES) send_byte(text_byte(), $urandom_range(19) == 0);
			drain();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_token_classes();
		test_line_pairs();
		test_buffer_end();
		test_mode_change();
		test_index_count();
		test_backpressure();
		test_random_text();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_labels.size() != 0)
			report_mismatch("results never arrived");
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/ttbm_pkg.sv
hdl/ttbm_classify.sv
hdl/text_token_boundary_marker.sv
dv/tb_top.sv
